// ===== sv/bma_pkg.sv =====
// Shared constants and types for the binary32 magnitude adder.
// No dependencies.
package bma_pkg;
	localparam int FRAC_W = 23;
	localparam int EXP_W  = 8;
	localparam int SIG_W  = FRAC_W + 1;
	localparam int WORD_W = 32;
	localparam int SUM_W  = EXP_W + FRAC_W;

	// aligned operand pair handed from align to add
	typedef struct packed {
		logic [EXP_W-1:0] big_e;
		logic [SIG_W-1:0] big_m;
		logic [SIG_W-1:0] small_m;
	} align_t;
endpackage

// ===== sv/binary32_magnitude_adder.sv =====
// Top level of the binary32 magnitude adder.
// Depends on bma_pkg, bma_align and bma_add.
//
// Usage:
//   Input channel carries operand_a/operand_b; a word is taken when in_valid
//   is high and in_stall is low. Signs are ignored, every operand is treated
//   as normal with a hidden one, and the fraction is truncated.
//   Output channel carries sum_bits and exponent_overflow under out_valid /
//   out_stall.
//   An accepted word passes the input register, then the result register,
//   before out_valid. Throughput: one word per cycle while the receiver does
//   not stall; the align/add path between the two registers sets the clock rate.
//   in_stall is raised only when the result register holds a word that the
//   receiver stalls and the input register is full too; while stalled,
//   outputs hold.
//   Reset (arst_n low) empties both registers; no word is in flight after.
module binary32_magnitude_adder (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [bma_pkg::WORD_W-1:0] operand_a,
	input  logic [bma_pkg::WORD_W-1:0] operand_b,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [bma_pkg::SUM_W-1:0] sum_bits,
	output logic                      exponent_overflow
);
	import bma_pkg::*;

	logic              v_s1, v_s2;
	logic [WORD_W-1:0] a_s1, b_s1;
	logic [SUM_W-1:0]  sum_s2;
	logic              ovf_s2;
	logic              adv_s2, adv_s1;
	align_t            aligned;
	logic [SUM_W-1:0]  sum_c;
	logic              ovf_c;

	assign adv_s2   = !v_s2 || !out_stall;
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_stall = !adv_s1;

	bma_align u_align (.operand_a(a_s1), .operand_b(b_s1), .aligned(aligned));
	bma_add   u_add   (.aligned(aligned), .sum_bits(sum_c), .exponent_overflow(ovf_c));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= in_valid;
			if (adv_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			a_s1 <= operand_a;
			b_s1 <= operand_b;
		end
		if (adv_s2 && v_s1) begin
			sum_s2 <= sum_c;
			ovf_s2 <= ovf_c;
		end
	end

	assign out_valid         = v_s2;
	assign sum_bits          = sum_s2;
	assign exponent_overflow = ovf_s2;

`ifndef NO_ASSERTIONS
	// stall toward the sender only when both stages are full and blocked
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && out_stall))
		else $error("in_stall without a full blocked pipeline");
	// an accepted word reaches the result register when the output is free
	a_move: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !(v_s2 && out_stall)) |=> v_s2)
		else $error("word lost between stages");
	// a blocked result holds its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(sum_bits)
		&& $stable(exponent_overflow)))
		else $error("stalled result changed");
`endif
endmodule

// ===== sv/bma_align.sv =====
// Exponent compare and right alignment of the smaller significand.
// Depends on bma_pkg.
module bma_align (
	input  logic [bma_pkg::WORD_W-1:0] operand_a,
	input  logic [bma_pkg::WORD_W-1:0] operand_b,
	output bma_pkg::align_t            aligned
);
	import bma_pkg::*;

	logic [EXP_W-1:0] ea, eb, diff;
	logic [SIG_W-1:0] ma, mb, sm;
	logic             a_big;

	always_comb begin
		ea    = operand_a[WORD_W-2 -: EXP_W];
		eb    = operand_b[WORD_W-2 -: EXP_W];
		ma    = {1'b1, operand_a[FRAC_W-1:0]};
		mb    = {1'b1, operand_b[FRAC_W-1:0]};
		a_big = (ea >= eb);
		diff  = a_big ? (ea - eb) : (eb - ea);
		sm    = a_big ? mb : ma;
		aligned.big_e   = a_big ? ea : eb;
		aligned.big_m   = a_big ? ma : mb;
		// shifts of 24 or more clear the operand completely
		aligned.small_m = (diff >= EXP_W'(SIG_W)) ? '0 : (sm >> diff);
	end
endmodule

// ===== sv/bma_add.sv =====
// Significand add, one-bit normalize and exponent bump.
// Depends on bma_pkg.
module bma_add (
	input  bma_pkg::align_t           aligned,
	output logic [bma_pkg::SUM_W-1:0] sum_bits,
	output logic                      exponent_overflow
);
	import bma_pkg::*;

	logic [SIG_W:0]   sum;
	logic [EXP_W:0]   res_e;
	logic [FRAC_W-1:0] frac;

	always_comb begin
		sum   = {1'b0, aligned.big_m} + {1'b0, aligned.small_m};
		res_e = {1'b0, aligned.big_e} + {{EXP_W{1'b0}}, sum[SIG_W]};
		frac  = sum[SIG_W] ? sum[SIG_W-1:1] : sum[FRAC_W-1:0];
		sum_bits          = {res_e[EXP_W-1:0], frac};
		exponent_overflow = res_e[EXP_W];
	end
endmodule

// ===== tb/tb_binary32_magnitude_adder.sv =====
// Testbench for binary32_magnitude_adder: directed table then random operand pairs,
// checked against table or in-bench predicted sums. Depends on bma_pkg and the RTL.
module tb_binary32_magnitude_adder;
	timeunit 1ns;
	timeprecision 1ps;
	import bma_pkg::*;

	localparam int N_RANDOM = 1800;
	localparam int TAIL_START = 1500;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic             ovf;
	} mag_sum_t;

	typedef struct {
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		logic              known;
		mag_sum_t          res;
	} vec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [WORD_W-1:0] operand_a = '0;
	logic [WORD_W-1:0] operand_b = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [SUM_W-1:0] sum_bits;
	logic exponent_overflow;

	mag_sum_t pending_sums[$];
	int mismatches = 0;
	int sent = 0;
	bit tail = 1'b0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	vec_t vecs[$];

	binary32_magnitude_adder uut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.operand_a(operand_a), .operand_b(operand_b), .out_valid(out_valid),
		.out_stall(out_stall), .sum_bits(sum_bits), .exponent_overflow(exponent_overflow)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic mag_sum_t add_magnitudes(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
		logic [EXP_W-1:0] ea, eb, big_e;
		logic [SIG_W-1:0] ma, mb, big_m, small_m;
		logic [EXP_W-1:0] diff;
		logic [SIG_W:0] total;
		logic [EXP_W:0] res_e;
		mag_sum_t r;
		ea = a[30:23];
		eb = b[30:23];
		ma = {1'b1, a[22:0]};
		mb = {1'b1, b[22:0]};
		if (ea >= eb) begin
			big_e = ea; big_m = ma; small_m = mb; diff = ea - eb;
		end else begin
			big_e = eb; big_m = mb; small_m = ma; diff = eb - ea;
		end
		small_m = (diff >= SIG_W) ? '0 : small_m >> diff;
		total = {1'b0, big_m} + {1'b0, small_m};
		res_e = {1'b0, big_e};
		if (total[SIG_W]) begin
			total = total >> 1;
			res_e = res_e + {{EXP_W{1'b0}}, 1'b1};
		end
		r.sum = {res_e[EXP_W-1:0], total[FRAC_W-1:0]};
		r.ovf = res_e[EXP_W];
		return r;
	endfunction

	function automatic logic [WORD_W-1:0] make_word(logic [7:0] e, logic [22:0] f);
		return {1'($urandom_range(0, 1)), e, f};
	endfunction

	task automatic add_vec(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b, logic known,
			mag_sum_t res);
		vec_t v;
		v.a = a; v.b = b; v.known = known; v.res = res;
		vecs.push_back(v);
	endtask

	// sender
	initial begin
		int gap;
		logic [7:0] e;
		add_vec(32'h0000_0000, 32'h0000_0000, 1, '{31'h0080_0000, 1'b0});
		add_vec(32'h3F80_0000, 32'h3F80_0000, 1, '{31'h4000_0000, 1'b0});
		add_vec(32'hBF80_0000, 32'h3F80_0000, 1, '{31'h4000_0000, 1'b0});
		add_vec(32'h7F80_0000, 32'h7F80_0000, 1, '{31'h0000_0000, 1'b1});
		add_vec(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, '{31'h007F_FFFF, 1'b1});
		add_vec(32'h7FFF_FFFF, 32'h0000_0000, 0, '0);
		add_vec(32'h3F80_0000, 32'h3380_0000, 0, '0); // diff 24, shifted out
		add_vec(32'h3F80_0000, 32'h3400_0000, 0, '0); // diff 23
		add_vec(32'h3400_0000, 32'h3F80_0000, 0, '0);
		add_vec(32'h3FFF_FFFF, 32'h3FFF_FFFF, 0, '0);
		add_vec(32'h3FFF_FFFF, 32'h3400_0001, 0, '0);
		add_vec(32'h0040_0000, 32'h7FC0_0000, 0, '0);
		add_vec(32'h5555_5555, 32'hAAAA_AAAA, 0, '0);
		add_vec(32'hAAAA_AAAA, 32'h5555_5555, 0, '0);
		add_vec(32'h7F7F_FFFF, 32'h7F00_0000, 0, '0);
		for (int i = 0; i < N_RANDOM; i++) begin
			case ($urandom_range(0, 3))
				0: add_vec($urandom, $urandom, 0, '0);
				1: begin
					e = 8'($urandom);
					add_vec(make_word(e, 23'($urandom)),
						make_word(e + 8'($urandom_range(0, 3)), 23'($urandom)), 0, '0);
				end
				2: begin
					e = 8'($urandom);
					add_vec(make_word(e, 23'($urandom)),
						make_word(e - 8'($urandom_range(20, 28)), 23'($urandom)), 0, '0);
				end
				default: add_vec(make_word(8'($urandom_range(250, 255)), 23'($urandom)),
					make_word(8'($urandom_range(240, 255)), 23'($urandom)), 0, '0);
			endcase
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (vecs[i]) begin
			if (i == 400) begin
				// let everything drain before going on
				in_valid <= 1'b0;
				while (pending_sums.size() != 0) @(posedge clk);
			end
			if (i == 600) hold_req = 1'b1;
			if (i == TAIL_START) tail = 1'b1;
			if (!tail && i > 20 && $urandom_range(0, 9) == 0) begin
				in_valid <= 1'b0;
				gap = $urandom_range(1, 12);
				repeat (gap) @(posedge clk);
			end
			in_valid <= 1'b1;
			operand_a <= vecs[i].a;
			operand_b <= vecs[i].b;
			@(posedge clk);
			while (in_stall) @(posedge clk);
			// accepted at this edge
			if (vecs[i].known) pending_sums.push_back(vecs[i].res);
			else pending_sums.push_back(add_magnitudes(vecs[i].a, vecs[i].b));
			sent++;
		end
		in_valid <= 1'b0;
		while (pending_sums.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0) $display("[binary32_magnitude_adder] OK");
		else $display("[binary32_magnitude_adder] ERROR");
		$finish;
	end

	// receiver stall pattern
	initial begin
		int burst;
		@(posedge arst_n);
		forever begin
			if (hold_req && !hold_done) begin
				out_stall <= 1'b1;
				repeat (40) @(posedge clk);
				hold_done = 1'b1;
				out_stall <= 1'b0;
				@(posedge clk);
			end else if (!tail && $urandom_range(0, 7) == 0) begin
				burst = $urandom_range(1, 12);
				out_stall <= 1'b1;
				repeat (burst) @(posedge clk);
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				@(posedge clk);
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		mag_sum_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_sums.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected word: sum %h ovf %b", sum_bits,
					exponent_overflow);
			end else begin
				want = pending_sums.pop_front();
				if (want.sum !== sum_bits || want.ovf !== exponent_overflow) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp sum %h ovf %b, got sum %h ovf %b",
							want.sum, want.ovf, sum_bits, exponent_overflow);
				end
			end
		end
	end

	initial begin
		#2ms;
		$display("[binary32_magnitude_adder] ERROR");
		$finish;
	end
endmodule
